>>> rtl/hmrp_pkg.sv
// ----------------------------------------------------------------------------
// hmrp_pkg: HTTP method and route parser package
// Shared types, method codes, terminator marks and the method prefix match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmrp_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned TAG_W   = 10;
  localparam int unsigned METH_W  = 3;
  localparam int unsigned START_W = 4;
  localparam int unsigned END_W   = 17;
  localparam int unsigned MARK_W  = 3;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  // Requests shorter than this are never matched against a method.
  localparam logic [LEN_W-1:0] MIN_LENGTH = LEN_W'(16);

  localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_NUL   = 8'h00;

  // First terminator seen among bytes 0..3: a space at 0..3, a NUL, or none.
  localparam logic [MARK_W-1:0] MARK_NUL  = 3'd4;
  localparam logic [MARK_W-1:0] MARK_NONE = 3'd7;

  typedef enum logic [METH_W-1:0] {
    METH_NONE    = 3'd0,
    METH_GET     = 3'd1,
    METH_POST    = 3'd2,
    METH_PUT     = 3'd3,
    METH_PATCH   = 3'd4,
    METH_DELETE  = 3'd5,
    METH_OPTIONS = 3'd6
  } method_t;

  // First four bytes of each method, byte 0 in the low bits.
  localparam logic [31:0] WORD_GET  = {8'h20, 8'h54, 8'h45, 8'h47}; // "GET "
  localparam logic [31:0] WORD_POST = {8'h54, 8'h53, 8'h4F, 8'h50}; // "POST"
  localparam logic [31:0] WORD_PUT  = {8'h20, 8'h54, 8'h55, 8'h50}; // "PUT "
  localparam logic [31:0] WORD_PATC = {8'h43, 8'h54, 8'h41, 8'h50}; // "PATC"
  localparam logic [31:0] WORD_DELE = {8'h45, 8'h4C, 8'h45, 8'h44}; // "DELE"
  localparam logic [31:0] WORD_OPTI = {8'h49, 8'h54, 8'h50, 8'h4F}; // "OPTI"

  typedef struct packed {
    method_t              meth;
    logic [START_W-1:0]   start;
  } match_t;

  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    method_t              meth;
    logic [START_W-1:0]   start;
    logic [END_W-1:0]     span_end;
    logic                 found;
  } result_t;

  // Compares the four prefix bytes with the method words.
  function automatic match_t match_method(input logic [31:0] word);
    match_t m;
    m.meth  = METH_NONE;
    m.start = '0;
    unique case (word)
      WORD_GET:  begin m.meth = METH_GET;     m.start = START_W'(4); end
      WORD_POST: begin m.meth = METH_POST;    m.start = START_W'(5); end
      WORD_PUT:  begin m.meth = METH_PUT;     m.start = START_W'(4); end
      WORD_PATC: begin m.meth = METH_PATCH;   m.start = START_W'(6); end
      WORD_DELE: begin m.meth = METH_DELETE;  m.start = START_W'(7); end
      WORD_OPTI: begin m.meth = METH_OPTIONS; m.start = START_W'(8); end
      default:   begin m.meth = METH_NONE;    m.start = '0;          end
    endcase
    return m;
  endfunction

endpackage

>>> rtl/http_method_route_parser.sv
// ----------------------------------------------------------------------------
// http_method_route_parser: HTTP method and route parser
// Parses an HTTP request one byte per item and reports method and route span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block takes one request byte per item and accepts a new item in every
// cycle while in_tready is high; each result is registered into the output
// register, or into the skid register while the output is stalled.
// The per-request state (byte position, first three bytes, early terminator
// mark, method and route start) is updated in the same cycle, which is what
// lets bytes follow each other without gaps. The result side has an output
// register and one skid register: the input stays ready while a result waits,
// and only drops ready when both hold a result that the sink has not taken.
// Each request gives at most one result. For requests of at least 16 bytes the
// first four bytes are matched against GET, POST, PUT, PATCH, DELETE and
// OPTIONS on the byte at position 3; the search for the first space then runs
// from the route start, and the route end is that space's position minus one
// (which is -1 for a space at position 0 of an unmatched request). A NUL, the
// byte flagged by tlast, or the byte at position length-1 without a space
// ends the request with method 0 and route_found low. A first-byte flag in
// in_tuser always restarts parsing from a clean state at position 0.

module http_method_route_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // data_byte [7:0], request_length [23:8], request_tag [33:24], zeros above
  input  logic [hmrp_pkg::IN_TDATA_W-1:0] in_tdata,
  // first_byte
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // result_tag [9:0], method [12:10], span_start [16:13], span_end [33:17]
  output logic [hmrp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // route_found
  output logic                            out_tuser
);

  import hmrp_pkg::*;

  // Input fields.
  logic [DATA_W-1:0] in_byte;
  logic [LEN_W-1:0]  in_len;
  logic [TAG_W-1:0]  in_tag;
  logic              in_acc;

  assign in_byte = in_tdata[7:0];
  assign in_len  = in_tdata[23:8];
  assign in_tag  = in_tdata[33:24];
  assign in_acc  = in_tvalid && in_tready;

  // Per-request state.
  logic [LEN_W-1:0]  pos_r,  pos_nxt;
  logic [23:0]       pre_r,  pre_nxt;
  logic [MARK_W-1:0] mark_r, mark_nxt;
  method_t           meth_r, meth_nxt;
  logic [START_W-1:0] rs_r,  rs_nxt;
  logic              sent_r, sent_nxt;

  // Result stage: output register plus one skid register.
  result_t           out_r,  skid_r;
  logic              out_valid_r, skid_valid_r;

  // Working values, with a first-byte flag applied as a clear.
  logic [LEN_W-1:0]   pos;
  logic [23:0]        pre;
  logic [MARK_W-1:0]  mark;
  method_t            meth;
  logic [START_W-1:0] rs;
  logic               sent;

  logic               in_range, is_sp, is_nul, term, at_end;
  logic [LEN_W:0]     pos_inc;
  logic [MARK_W-1:0]  mark_upd;
  match_t             mt;
  method_t            meth_upd;
  logic [START_W-1:0] rs_upd;
  logic               res_v;
  result_t            res;

  always_comb begin
    pos  = in_tuser ? '0        : pos_r;
    pre  = in_tuser ? '0        : pre_r;
    mark = in_tuser ? MARK_NONE : mark_r;
    meth = in_tuser ? METH_NONE : meth_r;
    rs   = in_tuser ? '0        : rs_r;
    sent = in_tuser ? 1'b0      : sent_r;

    is_sp    = (in_byte == CHAR_SPACE);
    is_nul   = (in_byte == CHAR_NUL);
    term     = is_sp || is_nul;
    in_range = (pos < in_len);
    pos_inc  = {1'b0, pos} + (LEN_W+1)'(1);
    at_end   = in_tlast || (pos_inc >= {1'b0, in_len});

    // Remember the first terminator among bytes 0..3.
    mark_upd = mark;
    if ((pos < LEN_W'(4)) && in_range && (mark == MARK_NONE) && term) begin
      mark_upd = is_nul ? MARK_NUL : pos[MARK_W-1:0];
    end

    // The method is decided on the byte at position 3.
    mt = match_method({in_byte, pre});
    meth_upd = meth;
    rs_upd   = rs;
    if (pos == LEN_W'(3)) begin
      if (in_len >= MIN_LENGTH) begin
        meth_upd = mt.meth;
        rs_upd   = mt.start;
      end else begin
        meth_upd = METH_NONE;
        rs_upd   = '0;
      end
    end

    res_v         = 1'b0;
    res.tag       = in_tag;
    res.meth      = METH_NONE;
    res.start     = rs_upd;
    res.span_end  = '0;
    res.found     = 1'b0;

    if (!sent) begin
      priority if ((pos >= LEN_W'(4)) && in_range &&
                   (pos >= LEN_W'(rs)) && term) begin
        // Space ends the route; a NUL ends the request without one.
        res_v         = 1'b1;
        res.found     = is_sp;
        res.meth      = is_sp ? meth : METH_NONE;
        res.span_end  = is_sp ? ({1'b0, pos} - END_W'(1)) : '0;
      end else if ((pos == LEN_W'(3)) && (meth_upd == METH_NONE) &&
                   (mark_upd != MARK_NONE)) begin
        // Unmatched prefix with a terminator already seen in bytes 0..3.
        res_v         = 1'b1;
        res.start     = '0;
        res.found     = !mark_upd[2];
        res.span_end  = mark_upd[2] ? '0 : (END_W'(mark_upd) - END_W'(1));
      end else if (at_end) begin
        res_v = 1'b1;
        if (pos < LEN_W'(3)) begin
          // Short request: method unsupported, an early space still counts.
          res.start     = '0;
          res.found     = !mark_upd[2];
          res.span_end  = mark_upd[2] ? '0 : (END_W'(mark_upd) - END_W'(1));
        end
      end else begin
        res_v = 1'b0;
      end
    end

    // Next state.
    pos_nxt  = (pos == '1) ? pos : pos_inc[LEN_W-1:0];
    pre_nxt  = pre;
    mark_nxt = mark;
    meth_nxt = meth;
    rs_nxt   = rs;
    sent_nxt = sent;
    if (!sent) begin
      if (pos < LEN_W'(3)) begin
        pre_nxt[pos[1:0]*8 +: 8] = in_byte;
      end
      mark_nxt = mark_upd;
      meth_nxt = meth_upd;
      rs_nxt   = rs_upd;
      sent_nxt = res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pre_r  <= '0;
      mark_r <= MARK_NONE;
      meth_r <= METH_NONE;
      rs_r   <= '0;
      sent_r <= 1'b0;
    end else if (in_acc) begin
      pos_r  <= pos_nxt;
      pre_r  <= pre_nxt;
      mark_r <= mark_nxt;
      meth_r <= meth_nxt;
      rs_r   <= rs_nxt;
      sent_r <= sent_nxt;
    end
  end

  // Result queue: the skid register only fills while the output is stalled.
  logic new_res;
  assign new_res   = in_acc && res_v;
  assign in_tready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r  <= new_res;
        end
      end else if (out_valid_r) begin
        if (new_res) begin
          skid_valid_r <= 1'b1;
        end
      end else begin
        out_valid_r <= new_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_tready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (!out_valid_r) begin
      out_r <= res;
    end
    if (out_valid_r && !out_tready && new_res) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r.span_end, out_r.start, out_r.meth, out_r.tag};
  assign out_tuser  = out_r.found;

  // The skid register never holds a result unless the output register does.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register valid while output register empty");

  // A found route with a supported method always starts past the method.
  a_found_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_r.found && (out_r.meth != METH_NONE)) |->
      (out_r.start >= START_W'(4)))
    else $error("matched route reported with a start inside the method");

  // A result without a route carries no method and no end offset.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_r.found) |->
      ((out_r.meth == METH_NONE) && (out_r.span_end == '0)))
    else $error("not-found result carries a method or route end");

  // Once a request has its result, later bytes of it give nothing.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && sent_r && !in_tuser) |-> !res_v)
    else $error("second result produced for one request");

endmodule
